@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the checker files
// no dependencies; the user supplies clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock edge out of reset
`define CHK_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/tccw_pkg.sv @@
// types, constants and helpers of the text console character writer
// no dependencies
`default_nettype none

package tccw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_WIDTH  = 8;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = 11;
  localparam int TAB_W  = $clog2(TAB_WIDTH);

  typedef logic [COL_W-1:0]  col_t;
  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [15:0]       cell_t;
  typedef logic [1:0]        op_t;

  localparam cell_t BLANK_CELL = 16'h0720;
  localparam cell_t ZERO_CELL  = 16'h0000;
  localparam logic [7:0] ATTR_RESET = 8'h07;

  localparam op_t OP_PUT    = 2'd0;
  localparam op_t OP_READ   = 2'd1;
  localparam op_t OP_SETCUR = 2'd2;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // register index taken from the word address
  localparam logic REG_TEXT_ATTR = 1'b0;

  function automatic addr_t cell_addr(input row_t r, input col_t c);
    cell_addr = ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/text_console_char_writer_top.sv @@
// text console character writer: cell store, cursor and put/read/set-cursor items
// depends on tccw_pkg
//
// input channel: in_valid/in_ready carry one item per transfer (op, char_code,
// cell_index, new_column, new_row); output channel: out_valid/out_ready carry
// one result per item (read_data, cursor_pos, cursor_column, cursor_row).
// configuration: APB-style port, text_attribute at byte address 0, pready high.
// the screen lives in one 2000 x 16 memory with one write and one read port,
// read data registered; all writes go through one registered write request.
// carriage return, backspace, cursor set, unused op and a newline off the last
// row go from the transfer straight to the done state, which registers the result;
// printable chars first pass the write state and cell reads the read state; a tab
// writes one cell per cycle up to the next tab stop (up to 8 cells).
// a newline on the last row, or a char or tab wrapping past it, scrolls: one
// cell moved per cycle plus one blank per cycle for the last row, bounded by the
// memory port; after reset a clearing pass zeroes the store one cell per cycle,
// with in_ready low; configuration writes are taken meanwhile.
// a new item is taken while a result waits; if out_ready stays low the block
// holds the finished item and then stops taking input until the result moves
`default_nettype none

module text_console_char_writer_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tccw_pkg::op_t        in_op,
  input  logic [7:0]           in_char_code,
  input  tccw_pkg::addr_t      in_cell_index,
  input  tccw_pkg::col_t       in_new_column,
  input  tccw_pkg::row_t       in_new_row,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tccw_pkg::cell_t      out_read_data,
  output tccw_pkg::addr_t      out_cursor_pos,
  output tccw_pkg::col_t       out_cursor_column,
  output tccw_pkg::row_t       out_cursor_row,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_PLAIN = 3'd3;
  localparam logic [2:0] ST_MOVE  = 3'd4;
  localparam logic [2:0] ST_BLANK = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  localparam tccw_pkg::addr_t LAST_CELL = tccw_pkg::ADDR_W'(tccw_pkg::CELL_COUNT - 1);
  localparam tccw_pkg::addr_t LAST_MOVE =
    tccw_pkg::ADDR_W'(tccw_pkg::CELL_COUNT - tccw_pkg::COLUMNS - 1);
  localparam tccw_pkg::addr_t CELLS_A = tccw_pkg::ADDR_W'(tccw_pkg::CELL_COUNT);
  localparam tccw_pkg::addr_t COLS_A  = tccw_pkg::ADDR_W'(tccw_pkg::COLUMNS);
  localparam tccw_pkg::col_t  COLS_C  = tccw_pkg::COL_W'(tccw_pkg::COLUMNS);
  localparam tccw_pkg::row_t  LAST_ROW = tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1);

  tccw_pkg::cell_t mem [tccw_pkg::CELL_COUNT];

  logic [2:0]      state_r, state_nxt;
  tccw_pkg::addr_t cnt_r, cnt_nxt;
  tccw_pkg::col_t  col_r, col_nxt;
  tccw_pkg::row_t  row_r, row_nxt;
  logic [7:0]      attr_r;
  logic [7:0]      ch_r, ch_nxt;
  logic            tab_r, tab_nxt;
  logic            ret_r, ret_nxt;
  tccw_pkg::cell_t rd_r, rd_nxt;
  logic            rng_r, rng_nxt;
  logic            fwd_r, fwd_nxt;
  tccw_pkg::cell_t fwd_data_r, fwd_data_nxt;

  logic            we_r, we_nxt;
  tccw_pkg::addr_t waddr_r, waddr_nxt;
  logic            wsrc_r, wsrc_nxt;
  tccw_pkg::cell_t wdata_r, wdata_nxt;
  tccw_pkg::cell_t wr_data;
  tccw_pkg::addr_t raddr;
  tccw_pkg::cell_t mem_rdata_r;

  logic            out_valid_r, out_valid_nxt;
  tccw_pkg::cell_t out_rd_r, out_rd_nxt;
  tccw_pkg::addr_t out_pos_r, out_pos_nxt;
  tccw_pkg::col_t  out_col_r, out_col_nxt;
  tccw_pkg::row_t  out_row_r, out_row_nxt;

  logic            out_free;
  logic            accept;
  logic            cfg_wr;
  tccw_pkg::col_t  col_inc;
  tccw_pkg::col_t  bs_col;
  tccw_pkg::row_t  bs_row;
  tccw_pkg::addr_t bs_addr;
  tccw_pkg::addr_t cur_addr;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) || ((state_r == ST_DONE) && out_free);
  assign accept   = in_valid && in_ready;
  assign wr_data  = wsrc_r ? mem_rdata_r : wdata_r;
  assign col_inc  = col_r + 1'b1;
  assign cur_addr = tccw_pkg::cell_addr(row_r, col_r);

  assign out_valid         = out_valid_r;
  assign out_read_data     = out_rd_r;
  assign out_cursor_pos    = out_pos_r;
  assign out_cursor_column = out_col_r;
  assign out_cursor_row    = out_row_r;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == tccw_pkg::REG_TEXT_ATTR);
  assign prdata = (paddr[2] == tccw_pkg::REG_TEXT_ATTR) ? {24'h0, attr_r} : 32'h0;

  // backspace target
  always_comb begin
    bs_col = col_r;
    bs_row = row_r;
    if (col_r != '0) begin
      bs_col = col_r - 1'b1;
    end else if (row_r != '0) begin
      bs_col = COLS_C;
      bs_row = row_r - 1'b1;
    end
    bs_addr = tccw_pkg::cell_addr(bs_row, bs_col);
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    ch_nxt       = ch_r;
    tab_nxt      = tab_r;
    ret_nxt      = ret_r;
    rd_nxt       = rd_r;
    rng_nxt      = rng_r;
    fwd_nxt      = fwd_r;
    fwd_data_nxt = fwd_data_r;
    we_nxt       = 1'b0;
    waddr_nxt    = waddr_r;
    wsrc_nxt     = 1'b0;
    wdata_nxt    = wdata_r;
    raddr        = '0;
    out_rd_nxt   = out_rd_r;
    out_pos_nxt  = out_pos_r;
    out_col_nxt  = out_col_r;
    out_row_nxt  = out_row_r;
    out_valid_nxt = out_valid_r && !out_ready;

    case (state_r)
      ST_CLEAR: begin
        we_nxt    = 1'b1;
        waddr_nxt = cnt_r;
        wdata_nxt = tccw_pkg::ZERO_CELL;
        if (cnt_r == LAST_CELL) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
      end
      ST_READ: begin
        if (!rng_r) begin
          rd_nxt = tccw_pkg::ZERO_CELL;
        end else if (fwd_r) begin
          rd_nxt = fwd_data_r;
        end else begin
          rd_nxt = mem_rdata_r;
        end
        state_nxt = ST_DONE;
      end
      ST_PLAIN: begin
        if (col_r >= COLS_C) begin
          col_nxt = '0;
          if (row_r == LAST_ROW) begin
            cnt_nxt   = '0;
            ret_nxt   = 1'b1;
            state_nxt = ST_MOVE;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end else begin
          we_nxt    = 1'b1;
          waddr_nxt = cur_addr;
          wdata_nxt = {attr_r, ch_r};
          col_nxt   = col_inc;
          if (!tab_r || (col_inc[tccw_pkg::TAB_W-1:0] == '0)) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_MOVE: begin
        raddr     = cnt_r + COLS_A;
        we_nxt    = 1'b1;
        waddr_nxt = cnt_r;
        wsrc_nxt  = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == LAST_MOVE) begin
          state_nxt = ST_BLANK;
        end
      end
      ST_BLANK: begin
        we_nxt    = 1'b1;
        waddr_nxt = cnt_r;
        wdata_nxt = tccw_pkg::BLANK_CELL;
        if (cnt_r == LAST_CELL) begin
          cnt_nxt   = '0;
          state_nxt = ret_r ? ST_PLAIN : ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_rd_nxt    = rd_r;
          out_pos_nxt   = cur_addr;
          out_col_nxt   = col_r;
          out_row_nxt   = row_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (accept) begin
      rd_nxt    = tccw_pkg::ZERO_CELL;
      state_nxt = ST_DONE;
      case (in_op)
        tccw_pkg::OP_PUT: begin
          case (in_char_code)
            tccw_pkg::CH_LF: begin
              col_nxt = '0;
              if (row_r == LAST_ROW) begin
                cnt_nxt   = '0;
                ret_nxt   = 1'b0;
                state_nxt = ST_MOVE;
              end else begin
                row_nxt = row_r + 1'b1;
              end
            end
            tccw_pkg::CH_BS: begin
              col_nxt   = bs_col;
              row_nxt   = bs_row;
              we_nxt    = bs_addr < CELLS_A;
              waddr_nxt = bs_addr;
              wdata_nxt = tccw_pkg::BLANK_CELL;
            end
            tccw_pkg::CH_CR: begin
              col_nxt = '0;
            end
            tccw_pkg::CH_TAB: begin
              ch_nxt    = tccw_pkg::CH_SPACE;
              tab_nxt   = 1'b1;
              state_nxt = ST_PLAIN;
            end
            default: begin
              ch_nxt    = in_char_code;
              tab_nxt   = 1'b0;
              state_nxt = ST_PLAIN;
            end
          endcase
        end
        tccw_pkg::OP_READ: begin
          rng_nxt      = in_cell_index < CELLS_A;
          raddr        = (in_cell_index < CELLS_A) ? in_cell_index : '0;
          fwd_nxt      = we_r && (waddr_r == in_cell_index);
          fwd_data_nxt = wr_data;
          state_nxt    = ST_READ;
        end
        tccw_pkg::OP_SETCUR: begin
          col_nxt = (in_new_column > COLS_C) ? COLS_C : in_new_column;
          row_nxt = (in_new_row > LAST_ROW) ? LAST_ROW : in_new_row;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      attr_r      <= tccw_pkg::ATTR_RESET;
      we_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      we_r        <= we_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr) begin
        attr_r <= pwdata[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    ch_r       <= ch_nxt;
    tab_r      <= tab_nxt;
    ret_r      <= ret_nxt;
    rd_r       <= rd_nxt;
    rng_r      <= rng_nxt;
    fwd_r      <= fwd_nxt;
    fwd_data_r <= fwd_data_nxt;
    waddr_r    <= waddr_nxt;
    wsrc_r     <= wsrc_nxt;
    wdata_r    <= wdata_nxt;
    out_rd_r   <= out_rd_nxt;
    out_pos_r  <= out_pos_nxt;
    out_col_r  <= out_col_nxt;
    out_row_r  <= out_row_nxt;
  end

  // screen store
  always_ff @(posedge clk) begin
    if (we_r) begin
      mem[waddr_r] <= wr_data;
    end
    mem_rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/tccw_checker.sv @@
// port-level checks of the text console character writer, bound to the top level
// depends on tccw_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module tccw_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input tccw_pkg::cell_t      out_read_data,
  input tccw_pkg::addr_t      out_cursor_pos,
  input tccw_pkg::col_t       out_cursor_column,
  input tccw_pkg::row_t       out_cursor_row
);

  logic stalled;
  logic cur_ok;
  logic pos_ok;

  assign stalled = out_valid && !out_ready;
  assign cur_ok  = (out_cursor_column <= tccw_pkg::COL_W'(tccw_pkg::COLUMNS)) &&
                   (out_cursor_row <= tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1));
  assign pos_ok  = out_cursor_pos ==
                   tccw_pkg::cell_addr(out_cursor_row, out_cursor_column);

  // stalled result holds
  `CHK_NEXT(a_out_hold, stalled, out_valid && $stable(out_read_data) && $stable(out_cursor_pos), "result changed while stalled")

  `CHK_IMPLY(a_cursor_range, out_valid, cur_ok, "cursor out of range")

  `CHK_IMPLY(a_cursor_pos, out_valid, pos_ok, "cursor position does not match column and row")

  // clearing pass blocks input right after reset
  `CHK_IMPLY(a_clear_blocks, !$past(rst_n), !in_ready && !out_valid, "input taken during clearing pass")

endmodule

bind text_console_char_writer_top tccw_checker u_tccw_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_read_data     (out_read_data),
  .out_cursor_pos    (out_cursor_pos),
  .out_cursor_column (out_cursor_column),
  .out_cursor_row    (out_cursor_row)
);

`default_nettype wire

@@ test/console_result_checker.sv @@
// result checker for the text console character writer: mirrors the cell store,
// cursor and attribute, and compares every result transfer with the prediction
// depends on tccw_pkg
module console_result_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  tccw_pkg::op_t     in_op,
  input  logic [7:0]        in_char_code,
  input  tccw_pkg::addr_t   in_cell_index,
  input  tccw_pkg::col_t    in_new_column,
  input  tccw_pkg::row_t    in_new_row,
  input  logic              out_valid,
  input  logic              out_ready,
  input  tccw_pkg::cell_t   out_read_data,
  input  tccw_pkg::addr_t   out_cursor_pos,
  input  tccw_pkg::col_t    out_cursor_column,
  input  tccw_pkg::row_t    out_cursor_row,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                fail_count,
  output int                pending,
  output int                reports_checked,
  output int                scroll_count
);

  typedef struct packed {
    tccw_pkg::cell_t read_data;
    tccw_pkg::addr_t cursor_pos;
    tccw_pkg::col_t  cursor_column;
    tccw_pkg::row_t  cursor_row;
  } cursor_report_t;

  tccw_pkg::cell_t shadow_screen [tccw_pkg::CELL_COUNT];
  tccw_pkg::col_t  shadow_column;
  tccw_pkg::row_t  shadow_row;
  logic [7:0]      shadow_attr;
  cursor_report_t  awaited_reports [$];
  cursor_report_t  got_report;
  cursor_report_t  want_report;
  int              mismatches;
  int              checked;
  int              scrolls;

  function automatic void scroll_screen();
    for (int i = 0; i < tccw_pkg::CELL_COUNT - tccw_pkg::COLUMNS; i++) begin
      shadow_screen[i] = shadow_screen[i + tccw_pkg::COLUMNS];
    end
    for (int i = tccw_pkg::CELL_COUNT - tccw_pkg::COLUMNS; i < tccw_pkg::CELL_COUNT; i++) begin
      shadow_screen[i] = tccw_pkg::BLANK_CELL;
    end
    scrolls++;
  endfunction

  function automatic void line_feed();
    if (int'(shadow_row) + 1 >= tccw_pkg::ROWS) begin
      scroll_screen();
    end else begin
      shadow_row = shadow_row + 1'b1;
    end
    shadow_column = '0;
  endfunction

  function automatic void write_glyph(input logic [7:0] ch);
    int idx;
    if (int'(shadow_column) >= tccw_pkg::COLUMNS) begin
      line_feed();
    end
    idx = int'(shadow_row) * tccw_pkg::COLUMNS + int'(shadow_column);
    if (idx < tccw_pkg::CELL_COUNT) begin
      shadow_screen[idx] = {shadow_attr, ch};
    end
    shadow_column = shadow_column + 1'b1;
  endfunction

  function automatic void put_character(input logic [7:0] ch);
    int idx;
    case (ch)
      tccw_pkg::CH_LF: begin
        line_feed();
      end
      tccw_pkg::CH_BS: begin
        if (shadow_column != 0) begin
          shadow_column = shadow_column - 1'b1;
        end else if (shadow_row != 0) begin
          shadow_column = tccw_pkg::col_t'(tccw_pkg::COLUMNS);
          shadow_row = shadow_row - 1'b1;
        end
        idx = int'(shadow_row) * tccw_pkg::COLUMNS + int'(shadow_column);
        if (idx < tccw_pkg::CELL_COUNT) begin
          shadow_screen[idx] = tccw_pkg::BLANK_CELL;
        end
      end
      tccw_pkg::CH_CR: begin
        shadow_column = '0;
      end
      tccw_pkg::CH_TAB: begin
        do begin
          write_glyph(tccw_pkg::CH_SPACE);
        end while (int'(shadow_column) % tccw_pkg::TAB_WIDTH != 0);
      end
      default: begin
        write_glyph(ch);
      end
    endcase
  endfunction

  function automatic cursor_report_t console_apply(input tccw_pkg::op_t op,
                                                  input logic [7:0] ch,
                                                  input tccw_pkg::addr_t idx,
                                                  input tccw_pkg::col_t col,
                                                  input tccw_pkg::row_t row);
    cursor_report_t rep;
    rep.read_data = tccw_pkg::ZERO_CELL;
    case (op)
      tccw_pkg::OP_PUT: begin
        put_character(ch);
      end
      tccw_pkg::OP_READ: begin
        if (int'(idx) < tccw_pkg::CELL_COUNT) begin
          rep.read_data = shadow_screen[idx];
        end
      end
      tccw_pkg::OP_SETCUR: begin
        shadow_column = (int'(col) > tccw_pkg::COLUMNS) ?
                        tccw_pkg::col_t'(tccw_pkg::COLUMNS) : col;
        shadow_row = (int'(row) > tccw_pkg::ROWS - 1) ?
                     tccw_pkg::row_t'(tccw_pkg::ROWS - 1) : row;
      end
      default: begin
      end
    endcase
    rep.cursor_pos = tccw_pkg::addr_t'(int'(shadow_column) +
                                       int'(shadow_row) * tccw_pkg::COLUMNS);
    rep.cursor_column = shadow_column;
    rep.cursor_row = shadow_row;
    return rep;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tccw_pkg::CELL_COUNT; i++) begin
        shadow_screen[i] = tccw_pkg::ZERO_CELL;
      end
      shadow_column = '0;
      shadow_row = '0;
      shadow_attr = tccw_pkg::ATTR_RESET;
      awaited_reports.delete();
      mismatches = 0;
      checked = 0;
      scrolls = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == tccw_pkg::REG_TEXT_ATTR) begin
        shadow_attr = pwdata[7:0];
      end
      if (out_valid && out_ready) begin
        got_report = '{out_read_data, out_cursor_pos, out_cursor_column, out_cursor_row};
        if (awaited_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result transfer: data %h pos %0d col %0d row %0d",
                     got_report.read_data, got_report.cursor_pos,
                     got_report.cursor_column, got_report.cursor_row);
          end
        end else begin
          want_report = awaited_reports.pop_front();
          checked++;
          if (got_report != want_report) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch on result %0d: expected data %h pos %0d col %0d row %0d, got data %h pos %0d col %0d row %0d",
                       checked, want_report.read_data, want_report.cursor_pos,
                       want_report.cursor_column, want_report.cursor_row,
                       got_report.read_data, got_report.cursor_pos,
                       got_report.cursor_column, got_report.cursor_row);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        awaited_reports.push_back(console_apply(in_op, in_char_code, in_cell_index,
                                                in_new_column, in_new_row));
      end
    end
    fail_count <= mismatches;
    pending <= awaited_reports.size();
    reports_checked <= checked;
    scroll_count <= scrolls;
  end

endmodule

@@ test/text_console_char_writer_top_tb.sv @@
// testbench top for the text console character writer: clock, reset, item and
// attribute stimulus with handshake stalls, and the verdict
// depends on tccw_pkg, text_console_char_writer_top and console_result_checker
module text_console_char_writer_top_tb;

  localparam tccw_pkg::op_t OP_UNUSED = 2'd3;
  localparam int            LONG_HOLD = 400;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  tccw_pkg::op_t   in_op = tccw_pkg::OP_PUT;
  logic [7:0]      in_char_code = '0;
  tccw_pkg::addr_t in_cell_index = '0;
  tccw_pkg::col_t  in_new_column = '0;
  tccw_pkg::row_t  in_new_row = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  tccw_pkg::cell_t out_read_data;
  tccw_pkg::addr_t out_cursor_pos;
  tccw_pkg::col_t  out_cursor_column;
  tccw_pkg::row_t  out_cursor_row;
  logic            psel = 1'b0;
  logic            penable = 1'b0;
  logic            pwrite = 1'b0;
  logic [2:0]      paddr = '0;
  logic [31:0]     pwdata = '0;
  logic [31:0]     prdata;
  logic            pready;

  int fail_count;
  int pending;
  int reports_checked;
  int scroll_count;

  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int items_sent = 0;

  always #5 clk = ~clk;

  text_console_char_writer_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_char_code      (in_char_code),
    .in_cell_index     (in_cell_index),
    .in_new_column     (in_new_column),
    .in_new_row        (in_new_row),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_read_data     (out_read_data),
    .out_cursor_pos    (out_cursor_pos),
    .out_cursor_column (out_cursor_column),
    .out_cursor_row    (out_cursor_row),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  console_result_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_char_code      (in_char_code),
    .in_cell_index     (in_cell_index),
    .in_new_column     (in_new_column),
    .in_new_row        (in_new_row),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_read_data     (out_read_data),
    .out_cursor_pos    (out_cursor_pos),
    .out_cursor_column (out_cursor_column),
    .out_cursor_row    (out_cursor_row),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .pready            (pready),
    .fail_count        (fail_count),
    .pending           (pending),
    .reports_checked   (reports_checked),
    .scroll_count      (scroll_count)
  );

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      out_ready <= 1'b0;
      hold_served <= hold_served + 1;
      hold_left <= LONG_HOLD;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  task automatic offer_item(input tccw_pkg::op_t op, input logic [7:0] ch,
                            input tccw_pkg::addr_t idx, input tccw_pkg::col_t col,
                            input tccw_pkg::row_t row);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_char_code <= ch;
    in_cell_index <= idx;
    in_new_column <= col;
    in_new_row <= row;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic put_char(input logic [7:0] ch);
    offer_item(tccw_pkg::OP_PUT, ch, tccw_pkg::addr_t'($urandom_range(2047)),
               tccw_pkg::col_t'($urandom_range(127)), tccw_pkg::row_t'($urandom_range(31)));
  endtask

  task automatic read_cell(input tccw_pkg::addr_t idx);
    offer_item(tccw_pkg::OP_READ, 8'($urandom_range(255)), idx,
               tccw_pkg::col_t'($urandom_range(127)), tccw_pkg::row_t'($urandom_range(31)));
  endtask

  task automatic set_cursor(input tccw_pkg::col_t col, input tccw_pkg::row_t row);
    offer_item(tccw_pkg::OP_SETCUR, 8'($urandom_range(255)),
               tccw_pkg::addr_t'($urandom_range(2047)), col, row);
  endtask

  task automatic random_item();
    int         pick;
    int         sub;
    logic [7:0] ch;
    pick = $urandom_range(99);
    sub = $urandom_range(99);
    if (pick < 62) begin
      if (sub < 5) ch = tccw_pkg::CH_LF;
      else if (sub < 10) ch = tccw_pkg::CH_BS;
      else if (sub < 13) ch = tccw_pkg::CH_CR;
      else if (sub < 19) ch = tccw_pkg::CH_TAB;
      else if (sub < 84) ch = 8'($urandom_range(8'h7E, 8'h20));
      else ch = 8'($urandom_range(255));
      put_char(ch);
    end else if (pick < 82) begin
      if (sub < 80) begin
        read_cell(tccw_pkg::addr_t'($urandom_range(tccw_pkg::ROWS - 1) * tccw_pkg::COLUMNS +
                                    $urandom_range(tccw_pkg::COLUMNS - 1)));
      end else begin
        read_cell(tccw_pkg::addr_t'($urandom_range(2047)));
      end
    end else if (pick < 96) begin
      set_cursor((sub < 70) ? tccw_pkg::col_t'($urandom_range(tccw_pkg::COLUMNS))
                            : tccw_pkg::col_t'($urandom_range(127)),
                 ($urandom_range(99) < 70) ? tccw_pkg::row_t'($urandom_range(tccw_pkg::ROWS - 1))
                                          : tccw_pkg::row_t'($urandom_range(31)));
    end else begin
      offer_item(OP_UNUSED, 8'($urandom_range(255)), tccw_pkg::addr_t'($urandom_range(2047)),
                 tccw_pkg::col_t'($urandom_range(127)), tccw_pkg::row_t'($urandom_range(31)));
    end
  endtask

  // drop valid and wait until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_attr(input logic [7:0] attr);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {tccw_pkg::REG_TEXT_ATTR, 2'b00};
    pwdata <= {24'($urandom), attr};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input int count, input int s_pct, input int r_pct,
                           input int hold_at, input int pause_at);
    sender_idle_pct = s_pct;
    receiver_idle_pct = r_pct;
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_requests <= hold_requests + 1;
      if (i == pause_at) drain();
      random_item();
    end
  endtask

  initial begin
    #40_000_000;
    $display("timeout with %0d results still awaited", pending);
    $display("text_console_char_writer_top_tb NOT OK");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset attribute
    read_cell(tccw_pkg::addr_t'(0));
    put_char(8'h41);
    put_char(8'hFF);
    put_char(8'h00);
    put_char(tccw_pkg::CH_BS);
    put_char(tccw_pkg::CH_CR);
    put_char(tccw_pkg::CH_TAB);
    put_char(tccw_pkg::CH_TAB);
    read_cell(tccw_pkg::addr_t'(9));
    set_cursor(tccw_pkg::col_t'(127), tccw_pkg::row_t'(31));
    put_char(8'h78);
    put_char(tccw_pkg::CH_LF);
    set_cursor(tccw_pkg::col_t'(0), tccw_pkg::row_t'(0));
    put_char(tccw_pkg::CH_BS);
    read_cell(tccw_pkg::addr_t'(0));
    set_cursor(tccw_pkg::col_t'(0), tccw_pkg::row_t'(5));
    put_char(tccw_pkg::CH_BS);
    read_cell(tccw_pkg::addr_t'(400));
    read_cell(tccw_pkg::addr_t'(tccw_pkg::CELL_COUNT - 1));
    read_cell(tccw_pkg::addr_t'(2047));
    offer_item(OP_UNUSED, 8'hFF, tccw_pkg::addr_t'(2047), tccw_pkg::col_t'(127),
               tccw_pkg::row_t'(31));
    set_cursor(tccw_pkg::col_t'(80), tccw_pkg::row_t'(3));
    put_char(tccw_pkg::CH_TAB);
    set_cursor(tccw_pkg::col_t'(78), tccw_pkg::row_t'(24));
    put_char(tccw_pkg::CH_TAB);
    put_char(8'h7A);
    drain();

    write_attr(8'hFF);
    run_phase(250, 12, 47, 120, -1);
    drain();

    write_attr(8'h00);
    run_phase(250, 47, 12, -1, 125);
    drain();

    write_attr(8'($urandom_range(255)));
    run_phase(250, 0, 0, 50, -1);
    drain();
    repeat (20) @(posedge clk);

    $display("sent %0d items, checked %0d results, %0d scrolls", items_sent,
             reports_checked, scroll_count);
    $display("attributes 07, ff, 00 and random, under sender/receiver stall mixes");
    if (fail_count == 0) begin
      $display("text_console_char_writer_top_tb OK");
    end else begin
      $display("text_console_char_writer_top_tb NOT OK");
    end
    $finish;
  end

endmodule

@@ text_console_char_writer_top.f @@
+incdir+hw/rtl
hw/rtl/tccw_pkg.sv
hw/rtl/text_console_char_writer_top.sv
hw/rtl/tccw_checker.sv
test/console_result_checker.sv
test/text_console_char_writer_top_tb.sv
